// File: src/rti_pkg.sv
// Shared types and constants for the radial table interpolator.
package rti_pkg;

    // Field widths of the item and result ports
    localparam int KIND_W      = 2;
    localparam int TBL_FIELD_W = 2;
    localparam int ENTRY_W     = 10;
    localparam int SAMPLE_W    = 32;
    localparam int RADIUS_W    = 24;
    localparam int INV_W       = 24;
    localparam int LEN_W       = 11;
    localparam int POS_W       = RADIUS_W + INV_W;
    localparam int IDX_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int CMP_W       = IDX_W + 2;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [INV_W-1:0] INV_SPACING_RST  = 24'd65536;
    localparam logic [LEN_W-1:0] TABLE_LENGTH_RST = 11'd1024;

    // Default sizes
    localparam int NUM_TABLES_DEF  = 4;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_DEPTH       = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_CUBIC  = 2'd1,
        KIND_LINEAR = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic {
        REG_INV_SPACING  = 1'b0,
        REG_TABLE_LENGTH = 1'b1
    } t_reg_idx;

    // One input item as taken from the ports
    typedef struct packed {
        t_kind                      kind;
        logic [TBL_FIELD_W-1:0]     tbl;
        logic [ENTRY_W-1:0]         entry;
        logic [SAMPLE_W-1:0]        sample;
        logic [RADIUS_W-1:0]        radius;
    } t_in_item;

    // Classified work item passed from front to back
    typedef struct packed {
        logic                       is_load;
        logic                       linear;
        logic                       zero;
        logic                       beyond;
        logic [TBL_FIELD_W-1:0]     tbl;
        logic [IDX_W-1:0]           pos;
        logic [FRAC_W-1:0]          frac;
        logic [SAMPLE_W-1:0]        sample;
    } t_work;

    // One result item
    typedef struct packed {
        logic [SAMPLE_W-1:0]        value;
        logic                       beyond;
    } t_result;

endpackage

// File: src/radial_table_interpolator.sv
// Top level of the radial table interpolator: config registers, queues, front and back.
//
// channel   direction  transfer condition             payload
// input     in         push && !full                  i_kind, i_table_index, i_entry_index,
//                                                     i_sample, i_radius
// result    out        pop && !empty                  o_value, o_beyond_table
// config    in         psel && penable && pwrite      paddr, pwdata (prdata on reads)
//
// One item per cycle is taken while full is low; a query's result is formed after the
// 4-entry work queue by the back pipeline and then waits in the output queue.
// Rate is bounded by one read per bank per cycle over four entry-interleaved banks.
// Reset clears control and loads the register defaults; samples are undefined until loaded.
// Up to 16 results wait in the output queue; the back part takes an item only when a
// slot is reserved for its result, so a stalled consumer backs up to full.
module radial_table_interpolator #(
    parameter int NUM_TABLES  = rti_pkg::NUM_TABLES_DEF,
    parameter int TABLE_DEPTH = rti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item channel
    input  logic                              push,
    output logic                              full,
    input  logic [rti_pkg::KIND_W-1:0]        i_kind,
    input  logic [rti_pkg::TBL_FIELD_W-1:0]   i_table_index,
    input  logic [rti_pkg::ENTRY_W-1:0]       i_entry_index,
    input  logic signed [rti_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [rti_pkg::RADIUS_W-1:0]      i_radius,
    // Result channel
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rti_pkg::SAMPLE_W-1:0] o_value,
    output logic                              o_beyond_table,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rti_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rti_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rti_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int WORK_W = $bits(rti_pkg::t_work);
    localparam int RES_W  = $bits(rti_pkg::t_result);

    logic [rti_pkg::INV_W-1:0]  r_inv_spacing;
    logic [rti_pkg::LEN_W-1:0]  r_table_length;
    rti_pkg::t_reg_idx          reg_idx;
    logic                       cfg_wr;

    rti_pkg::t_in_item          in_item;
    rti_pkg::t_work             front_item;
    logic                       q_push, q_full, q_empty, q_pop;
    logic [WORK_W-1:0]          q_rdata;

    rti_pkg::t_result           out_item;
    logic                       out_push, out_full, out_taken;
    logic [RES_W-1:0]           out_rdata;
    rti_pkg::t_result           out_head;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = rti_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_spacing  <= rti_pkg::INV_SPACING_RST;
            r_table_length <= rti_pkg::TABLE_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rti_pkg::REG_INV_SPACING:  r_inv_spacing  <= pwdata[rti_pkg::INV_W-1:0];
                rti_pkg::REG_TABLE_LENGTH: r_table_length <= pwdata[rti_pkg::LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rti_pkg::REG_INV_SPACING:  prdata = rti_pkg::APB_DATA_W'(r_inv_spacing);
            rti_pkg::REG_TABLE_LENGTH: prdata = rti_pkg::APB_DATA_W'(r_table_length);
        endcase
    end

    // Front part
    assign in_item.kind   = rti_pkg::t_kind'(i_kind);
    assign in_item.tbl    = i_table_index;
    assign in_item.entry  = i_entry_index;
    assign in_item.sample = i_sample;
    assign in_item.radius = i_radius;

    rti_front #(
        .NUM_TABLES  (NUM_TABLES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (in_item),
        .o_full         (full),
        .i_inv_spacing  (r_inv_spacing),
        .i_table_length (r_table_length),
        .o_q_push       (q_push),
        .o_q_item       (front_item),
        .i_q_full       (q_full)
    );

    // Work queue between front and back
    rti_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (rti_pkg::QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back part
    rti_back #(
        .NUM_TABLES  (NUM_TABLES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_item    (rti_pkg::t_work'(q_rdata)),
        .o_q_pop     (q_pop),
        .i_out_taken (out_taken),
        .o_out_push  (out_push),
        .o_out_item  (out_item)
    );

    // Output queue
    assign out_taken = pop && !empty;

    rti_fifo #(
        .WIDTH (RES_W),
        .DEPTH (rti_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (out_taken),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign out_head       = rti_pkg::t_result'(out_rdata);
    assign o_value        = out_head.value;
    assign o_beyond_table = out_head.beyond;

`ifndef SYNTHESIS
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full output queue");

    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_beyond_table) |-> o_value == '0)
        else $error("result past table end carries a nonzero value");
`endif

endmodule

// File: src/rti_fifo.sv
// Small register-based FIFO used between and after the front and back parts.
module rti_fifo #(
    parameter int WIDTH = $bits(rti_pkg::t_work),
    parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/rti_front.sv
// Front part: takes items, forms the scaled position and classifies each item.
module rti_front #(
    parameter int NUM_TABLES  = rti_pkg::NUM_TABLES_DEF,
    parameter int TABLE_DEPTH = rti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  rti_pkg::t_in_item             i_item,
    output logic                          o_full,
    input  logic [rti_pkg::INV_W-1:0]     i_inv_spacing,
    input  logic [rti_pkg::LEN_W-1:0]     i_table_length,
    output logic                          o_q_push,
    output rti_pkg::t_work                o_q_item,
    input  logic                          i_q_full
);

    localparam int CMP_W = rti_pkg::CMP_W;

    logic                           r_s1_vld;
    rti_pkg::t_in_item              r_s1_item;
    logic [rti_pkg::POS_W-1:0]      r_s1_pos;

    logic                           s1_free;
    logic                           accept;
    logic [rti_pkg::IDX_W-1:0]      idx;
    logic [rti_pkg::FRAC_W-1:0]     frac;
    logic [CMP_W-1:0]               len_raw, len, idx_ext;
    logic                           tbl_ok, entry_ok, linear, beyond, keep;

    // Stage 1 moves when empty or when its item can leave
    assign s1_free = !r_s1_vld || !i_q_full;
    assign o_full  = !s1_free;
    assign accept  = i_push && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= i_push;
        end
    end

    // Input register with the radius scaling product
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
            r_s1_pos  <= i_item.radius * i_inv_spacing;
        end
    end

    // Split position; clamp table length into [2, TABLE_DEPTH]
    assign idx     = r_s1_pos[rti_pkg::POS_W-1 -: rti_pkg::IDX_W];
    assign frac    = r_s1_pos[rti_pkg::POS_W-rti_pkg::IDX_W-1 -: rti_pkg::FRAC_W];
    assign idx_ext = CMP_W'(idx);
    assign len_raw = CMP_W'(i_table_length);

    always_comb begin
        if (len_raw < CMP_W'(2)) begin
            len = CMP_W'(2);
        end else if (len_raw > CMP_W'(TABLE_DEPTH)) begin
            len = CMP_W'(TABLE_DEPTH);
        end else begin
            len = len_raw;
        end
    end

    // Classification
    assign tbl_ok   = 7'(r_s1_item.tbl) < 7'(NUM_TABLES);
    assign entry_ok = CMP_W'(r_s1_item.entry) < CMP_W'(TABLE_DEPTH);
    assign linear   = (r_s1_item.kind == rti_pkg::KIND_LINEAR) || (idx == '0);
    assign beyond   = linear ? (idx_ext + CMP_W'(1) >= len) : (idx_ext + CMP_W'(2) >= len);

    always_comb begin
        unique case (r_s1_item.kind)
            rti_pkg::KIND_LOAD:   keep = tbl_ok && entry_ok;
            rti_pkg::KIND_CUBIC:  keep = 1'b1;
            rti_pkg::KIND_LINEAR: keep = 1'b1;
            rti_pkg::KIND_NONE:   keep = 1'b0;
        endcase
    end

    always_comb begin
        o_q_item.is_load = (r_s1_item.kind == rti_pkg::KIND_LOAD);
        o_q_item.linear  = linear;
        o_q_item.zero    = !tbl_ok || beyond;
        o_q_item.beyond  = tbl_ok && beyond;
        o_q_item.tbl     = r_s1_item.tbl;
        o_q_item.pos     = o_q_item.is_load ? rti_pkg::IDX_W'(r_s1_item.entry) : idx;
        o_q_item.frac    = frac;
        o_q_item.sample  = r_s1_item.sample;
    end

    // Dropped items (unused kind, out-of-range load) leave without a transfer
    assign o_q_push = r_s1_vld && !i_q_full && keep;

endmodule

// File: src/rti_back.sv
// Back part: banked sample store and the interpolation pipeline.
module rti_back #(
    parameter int NUM_TABLES  = rti_pkg::NUM_TABLES_DEF,
    parameter int TABLE_DEPTH = rti_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  rti_pkg::t_work    i_q_item,
    output logic              o_q_pop,
    input  logic              i_out_taken,
    output logic              o_out_push,
    output rti_pkg::t_result  o_out_item
);

    localparam int ROWS      = (TABLE_DEPTH + 3) / 4;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int ADDR_W    = TBL_W + ROW_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int RESV_W    = $clog2(rti_pkg::OUT_DEPTH + 1);
    localparam int IDX_W     = rti_pkg::IDX_W;
    localparam int NSTG      = 9;

    typedef struct packed {
        logic                       zero;
        logic                       beyond;
        logic                       linear;
        logic [rti_pkg::FRAC_W-1:0] frac;
    } t_side;

    // Control
    logic [RESV_W-1:0]      r_resv;
    logic [NSTG:1]          r_vld;
    logic                   res_inc;

    // Memory access
    logic [IDX_W-1:0]       base;
    logic [TBL_W-1:0]       tbl_bits;
    logic [31:0]            r_rd [4];
    logic [1:0]             r_rot1;

    // Carried through the pipeline
    t_side                  r_side [1:NSTG];
    logic signed [31:0]     r_y00 [2:NSTG];
    logic signed [32:0]     r_g1  [2:8];
    logic signed [33:0]     r_h2  [2:5];

    // Arithmetic stages
    logic signed [34:0]     r_i2;
    logic signed [53:0]     r_m1;
    logic [20:0]            r_sp;
    logic signed [18:0]     r_qh;
    logic [43:0]            r_t;
    logic signed [36:0]     r_p2;
    logic signed [35:0]     r_a;
    logic signed [53:0]     r_m2;
    logic signed [35:0]     r_b;
    logic signed [52:0]     r_m3;

    logic signed [31:0]     ym, y0, yp, yq;
    logic signed [32:0]     g0, g1, g2;
    logic signed [33:0]     h1, h2;
    logic signed [34:0]     i2;
    logic signed [18:0]     f_m2;
    logic signed [53:0]     m1_rnd;
    logic signed [18:0]     qh;
    logic [17:0]            ql;
    logic signed [19:0]     s3;
    logic signed [21:0]     sp_ext;
    logic signed [20:0]     fs3;
    logic signed [37:0]     a_sum;
    logic signed [17:0]     f_m1;
    logic signed [53:0]     m2_rnd;
    logic signed [37:0]     b_sum;
    logic signed [52:0]     m3_rnd;
    logic signed [37:0]     v_sum;
    logic [31:0]            v_sat;

    // Take the next item only with an output slot reserved for its result
    assign o_q_pop = !i_q_empty && (r_resv < RESV_W'(rti_pkg::OUT_DEPTH));
    assign res_inc = o_q_pop && !i_q_item.is_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv <= '0;
            r_vld  <= '0;
        end else begin
            unique case ({res_inc, i_out_taken})
                2'b10:   r_resv <= r_resv + RESV_W'(1);
                2'b01:   r_resv <= r_resv - RESV_W'(1);
                default: r_resv <= r_resv;
            endcase
            r_vld <= {r_vld[NSTG-1:1], res_inc};
        end
    end

    // Four banks by entry modulo 4: the four neighbors always hit distinct banks
    assign base     = i_q_item.pos - IDX_W'(1);
    assign tbl_bits = TBL_W'(i_q_item.tbl);

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [31:0]       r_mem [MEM_DEPTH];
        logic [1:0]        off;
        logic [IDX_W-1:0]  e_rd;
        logic [ADDR_W-1:0] raddr, waddr;
        logic              we;

        assign off   = 2'(k) - base[1:0];
        assign e_rd  = base + IDX_W'(off);
        assign raddr = {tbl_bits, e_rd[ROW_W+1:2]};
        assign waddr = {tbl_bits, i_q_item.pos[ROW_W+1:2]};
        assign we    = o_q_pop && i_q_item.is_load && (i_q_item.pos[1:0] == 2'(k));

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[waddr] <= i_q_item.sample;
            end
            r_rd[k] <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot1    <= base[1:0];
        r_side[1] <= '{zero: i_q_item.zero, beyond: i_q_item.beyond,
                       linear: i_q_item.linear, frac: i_q_item.frac};
    end

    // Stage 1: line up neighbors, forward differences
    always_comb begin
        unique case (r_rot1)
            2'd0: begin ym = r_rd[0]; y0 = r_rd[1]; yp = r_rd[2]; yq = r_rd[3]; end
            2'd1: begin ym = r_rd[1]; y0 = r_rd[2]; yp = r_rd[3]; yq = r_rd[0]; end
            2'd2: begin ym = r_rd[2]; y0 = r_rd[3]; yp = r_rd[0]; yq = r_rd[1]; end
            2'd3: begin ym = r_rd[3]; y0 = r_rd[0]; yp = r_rd[1]; yq = r_rd[2]; end
        endcase
        g0 = $signed({y0[31], y0}) - $signed({ym[31], ym});
        g1 = $signed({yp[31], yp}) - $signed({y0[31], y0});
        g2 = $signed({yq[31], yq}) - $signed({yp[31], yp});
        h1 = $signed({g1[32], g1}) - $signed({g0[32], g0});
        h2 = $signed({g2[32], g2}) - $signed({g1[32], g1});
        i2 = $signed({h2[33], h2}) - $signed({h1[33], h1});
    end

    // Stage 3: rounded quotient by 3*2^16, split q = qh*2^18 + ql
    assign m1_rnd = r_m1 + 54'sd98304;
    assign qh     = m1_rnd[52:34];
    assign ql     = m1_rnd[33:16];
    assign s3     = $signed({qh[18], qh}) + $signed({2'b00, ql});
    assign sp_ext = $signed({s3[19], s3[19], s3}) + 22'sd786432;

    // Stage 5: floor(q/3) = qh*87381 + floor((qh+ql)/3)
    assign fs3   = $signed({1'b0, r_t[43:24]}) - 21'sd262144;
    assign a_sum = $signed({r_h2[5][33], r_h2[5][33], r_h2[5][33], r_h2[5][33], r_h2[5]})
                 + $signed({r_p2[36], r_p2})
                 + $signed({{17{fs3[20]}}, fs3});

    // Stage 2 and 6 multiplier operands
    assign f_m2 = $signed({3'b000, r_side[2].frac}) - 19'sd131072;
    assign f_m1 = $signed({2'b00, r_side[6].frac}) - 18'sd65536;

    // Stage 7: b term, or the plain difference for two-point mode
    assign m2_rnd = r_m2 + 54'sd65536;
    assign b_sum  = $signed({{5{r_g1[7][32]}}, r_g1[7]}) + $signed(m2_rnd[53:17]);

    // Stage 9: final rounding, sum and saturation
    assign m3_rnd = r_m3 + 53'sd32768;
    assign v_sum  = $signed({{6{r_y00[9][31]}}, r_y00[9]}) + $signed({m3_rnd[52], m3_rnd[52:16]});

    always_comb begin
        if (v_sum > 38'sd2147483647) begin
            v_sat = 32'h7FFF_FFFF;
        end else if (v_sum < -38'sd2147483648) begin
            v_sat = 32'h8000_0000;
        end else begin
            v_sat = v_sum[31:0];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        for (int s = 2; s <= NSTG; s++) begin
            r_side[s] <= r_side[s-1];
        end
        for (int s = 3; s <= NSTG; s++) begin
            r_y00[s] <= r_y00[s-1];
        end
        for (int s = 3; s <= 8; s++) begin
            r_g1[s] <= r_g1[s-1];
        end
        for (int s = 3; s <= 5; s++) begin
            r_h2[s] <= r_h2[s-1];
        end
        r_y00[2] <= y0;
        r_g1[2]  <= g1;
        r_h2[2]  <= h2;
        r_i2     <= i2;
        r_m1     <= r_i2 * f_m2;
        r_sp     <= sp_ext[20:0];
        r_qh     <= qh;
        r_t      <= r_sp * 23'd5592406;
        r_p2     <= r_qh * 18'sd87381;
        r_a      <= a_sum[35:0];
        r_m2     <= r_a * f_m1;
        r_b      <= r_side[7].linear ? 36'(r_g1[7]) : b_sum[35:0];
        r_m3     <= r_b * $signed({1'b0, r_side[8].frac});
    end

    assign o_out_push        = r_vld[NSTG];
    assign o_out_item.value  = r_side[NSTG].zero ? '0 : v_sat;
    assign o_out_item.beyond = r_side[NSTG].beyond;

`ifndef SYNTHESIS
    a_resv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resv <= RESV_W'(rti_pkg::OUT_DEPTH))
        else $error("output reservations exceed queue depth");

    a_push_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> r_resv != '0)
        else $error("result leaves pipeline without a reserved slot");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule
